/* hw/rtl/stroke_font_command_generator_top_macros.svh */
// Assertion macros for the stroke font command generator.
// Used by stroke_font_command_generator_top; expects signals named clock and reset.
`ifndef STROKE_FONT_COMMAND_GENERATOR_TOP_MACROS_SVH
`define STROKE_FONT_COMMAND_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define SFCG_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication
`define SFCG_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

/* hw/rtl/sfcg_pkg.sv */
// Shared types and constants of the stroke font command generator.
// No dependencies; imported by stroke_font_command_generator_top.
package sfcg_pkg;

   // table depth must be a power of two (indices wrap by truncation)
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int MAX_STROKES = 31;
   localparam int CNT_W       = $clog2(MAX_STROKES + 1);
   localparam int ENTRY_W     = 48;

   localparam logic [15:0] HEADER_MARK = 16'd999;
   localparam logic [15:0] SCALE_RESET = 16'd14564;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   localparam logic [1:0] CMD_PEN_UP   = 2'd0;
   localparam logic [1:0] CMD_PEN_DOWN = 2'd1;
   localparam logic [1:0] CMD_MOVE     = 2'd2;
   localparam logic [1:0] CMD_DRAW     = 2'd3;

   typedef struct packed {
      logic              op;
      logic [9:0]        entry_index;
      logic signed [15:0] field_a;
      logic signed [15:0] field_b;
      logic signed [15:0] field_c;
      logic [7:0]        char_code;
   } req_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_LATCH,
      ST_PEN,
      ST_MOVE
   } state_type;

endpackage

/* hw/rtl/stroke_font_command_generator_top.sv */
// Top level of the stroke font command generator: sequencer, scaling datapath, font table.
// Depends on sfcg_pkg, sfcg_ram and stroke_font_command_generator_top_macros.svh.
//
// A request is taken when start is high and busy is low. A load request (op 0)
// writes one font table entry in its accept cycle and keeps busy low, so loads
// can follow each other in every cycle. A draw request (op 1) scans the table
// from entry 0 through the single read port of the table RAM, one entry per
// cycle, for the first header (field a = 999, field b = character code); the
// scan stops after the last entry. Each stroke after the header then goes
// through read, multiply, optional pen command and move/draw in turn. At
// most 31 strokes are drawn; larger header counts are clamped. Results appear
// on rsp for exactly one cycle each with rsp_valid high; the receiver cannot
// stall them, so it must take every strobe. rsp.last marks the final command
// of a character; a character that is missing, or whose header count is zero
// or negative, gives no results at all. After reset the table is cleared to
// zero by a pass over all 1024 entries during which busy is high;
// scale writes through csr_we/csr_wdata are taken at any time but are meant
// for idle periods. Positions are x = x_coord*scale + x_offset, y =
// y_coord*scale in 1/65536 mm, wrapping at 32 bits; x_offset advances to the
// last x of each drawn character.
module stroke_font_command_generator_top
   import sfcg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req,
   output logic        rsp_valid,
   output rsp_type     rsp,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

`include "stroke_font_command_generator_top_macros.svh"

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   state_type state_ff, state_in;

   // table clear sweep
   logic [IDX_W-1:0] clr_ff, clr_in;

   // header scan
   logic [IDX_W:0]   scan_ff, scan_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]       char_ff, char_in;

   // stroke walk
   logic [IDX_W-1:0] hdr_ff, hdr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] stroke_ff, stroke_in;
   logic             pen_new_ff, pen_new_in;
   logic [31:0]      prod_x_ff, prod_x_in;
   logic [31:0]      prod_y_ff, prod_y_in;

   // architectural state
   logic        pen_ff, pen_in;
   logic [31:0] x_off_ff, x_off_in;
   logic [15:0] scale_ff;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // table RAM ports
   logic             ram_we, ram_re;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   entry_type        ram_wdata, ram_rdata;

   logic accept;
   logic issuing;
   logic hit;
   logic scan_miss_end;
   logic signed [15:0] hdr_cnt;
   logic signed [33:0] mul_x, mul_y;
   logic [31:0] x_sum;

   sfcg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign issuing = (state_ff == ST_SEARCH) && (scan_ff < (IDX_W + 1)'(TABLE_DEPTH));
   assign hit     = rd_valid_ff && (ram_rdata.a == HEADER_MARK)
                    && (ram_rdata.b == {8'd0, char_ff});
   assign scan_miss_end = rd_valid_ff && !hit && (rd_idx_ff == LAST_IDX);
   assign hdr_cnt = $signed(ram_rdata.c);

   // signed coordinate times unsigned scale, both 17-bit signed operands
   assign mul_x = $signed({ram_rdata.a[15], ram_rdata.a}) * $signed({1'b0, scale_ff});
   assign mul_y = $signed({ram_rdata.b[15], ram_rdata.b}) * $signed({1'b0, scale_ff});
   assign x_sum = prod_x_ff + x_off_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req.op == OP_DRAW) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               state_in = (hdr_cnt > 16'sd0) ? ST_FETCH : ST_IDLE;
            end else if (scan_miss_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: state_in = ST_LATCH;
         ST_LATCH: state_in = ST_PEN;
         ST_PEN:   state_in = ST_MOVE;
         ST_MOVE: begin
            state_in = (stroke_ff == count_ff) ? ST_IDLE : ST_FETCH;
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   // datapath and outputs
   always_comb begin
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      rd_valid_in  = issuing;
      rd_idx_in    = scan_ff[IDX_W-1:0];
      char_in      = char_ff;
      hdr_in       = hdr_ff;
      count_in     = count_ff;
      stroke_in    = stroke_ff;
      pen_new_in   = pen_new_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      pen_in       = pen_ff;
      x_off_in     = x_off_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = scan_ff[IDX_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept && req.op == OP_LOAD) begin
               ram_we    = 1'b1;
               ram_waddr = IDX_W'(32'(req.entry_index));
               ram_wdata = '{a: req.field_a, b: req.field_b, c: req.field_c};
            end
            if (accept && req.op == OP_DRAW) begin
               scan_in = '0;
               char_in = req.char_code;
            end
         end
         ST_SEARCH: begin
            ram_re = issuing;
            if (issuing) begin
               scan_in = scan_ff + 1'b1;
            end
            if (hit) begin
               hdr_in    = rd_idx_ff;
               stroke_in = CNT_W'(1);
               count_in  = (hdr_cnt > 16'(MAX_STROKES)) ? CNT_W'(MAX_STROKES)
                                                        : hdr_cnt[CNT_W-1:0];
            end
         end
         ST_FETCH: begin
            ram_re    = 1'b1;
            ram_raddr = hdr_ff + IDX_W'(stroke_ff);
         end
         ST_LATCH: begin
            pen_new_in = ram_rdata.c[0];
            prod_x_in  = mul_x[31:0];
            prod_y_in  = mul_y[31:0];
         end
         ST_PEN: begin
            if (pen_new_ff != pen_ff) begin
               pen_in       = pen_new_ff;
               rsp_valid_in = 1'b1;
               rsp_in       = '{command: pen_new_ff ? CMD_PEN_DOWN : CMD_PEN_UP,
                                x_pos: '0, y_pos: '0, last: 1'b0};
            end
         end
         ST_MOVE: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{command: pen_ff ? CMD_DRAW : CMD_MOVE,
                             x_pos: x_sum, y_pos: prod_y_ff,
                             last: (stroke_ff == count_ff)};
            stroke_in    = stroke_ff + 1'b1;
            if (stroke_ff == count_ff) begin
               x_off_in = x_sum;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         pen_ff       <= 1'b0;
         x_off_ff     <= '0;
         scale_ff     <= SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_valid_ff  <= rd_valid_in;
         pen_ff       <= pen_in;
         x_off_ff     <= x_off_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            scale_ff <= csr_wdata;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      rd_idx_ff  <= rd_idx_in;
      char_ff    <= char_in;
      hdr_ff     <= hdr_in;
      count_ff   <= count_in;
      stroke_ff  <= stroke_in;
      pen_new_ff <= pen_new_in;
      prod_x_ff  <= prod_x_in;
      prod_y_ff  <= prod_y_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `SFCG_ASSERT_NOW(a_last_ends_busy, rsp_valid && rsp.last, !busy,
      "final command of a character while still busy")
   `SFCG_ASSERT_NEXT(a_no_rsp_after_accept, start && !busy, !rsp_valid,
      "result strobe right after a request was taken")
   `SFCG_ASSERT_NOW(a_pen_cmd_zero, rsp_valid && !rsp.command[1],
      rsp.x_pos == 32'sd0 && rsp.y_pos == 32'sd0 && !rsp.last,
      "pen command with position or last set")
   `SFCG_ASSERT_NOW(a_no_write_in_draw, state_ff != ST_IDLE && state_ff != ST_CLEAR,
      !ram_we, "font table written during a draw")
   `SFCG_ASSERT_NOW(a_stroke_in_range, state_ff == ST_FETCH,
      count_ff != '0 && stroke_ff != '0 && stroke_ff <= count_ff,
      "stroke counter out of range")

endmodule

/* hw/rtl/sfcg_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module sfcg_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
